@@ rtl/core/jpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick polar converter package
// Shared constants, register indexes, direction codes and the arctangent table.
// ----------------------------------------------------------------------------
package jpc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CORDIC_STEPS    = 20;
  localparam int ZW              = 31;
  localparam int AW              = 29;
  localparam int ADW             = 28;
  localparam int QA_BITS         = 12;

  localparam logic signed [ZW-1:0] DEG180 = 31'sd180000000;
  localparam logic signed [ZW-1:0] DEG360 = 31'sd360000000;
  localparam logic [AW-1:0]        ROUND_HALF = 29'd50000;
  localparam logic [ADW-1:0]       ANG_DIV_TOP = 28'd204800000;
  localparam logic [13:0]          POWER_SCALE = 14'd10000;
  localparam logic [11:0]          ANGLE_WRAP = 12'd3600;
  localparam logic [6:0]           POWER_MAX = 7'd100;

  localparam logic [11:0] RADIUS_RST = 12'd1400;
  localparam logic [6:0]  DEADZONE_RST = 7'd10;
  localparam logic [11:0] RIGHT_RST = 12'd3000;
  localparam logic [11:0] LEFT_RST = 12'd1000;
  localparam logic [11:0] UP_RST = 12'd3000;
  localparam logic [11:0] DOWN_RST = 12'd1000;

  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_DEADZONE = 3'd1;
  localparam logic [2:0] REG_RIGHT    = 3'd2;
  localparam logic [2:0] REG_LEFT     = 3'd3;
  localparam logic [2:0] REG_UP       = 3'd4;
  localparam logic [2:0] REG_DOWN     = 3'd5;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // Arctangent of 2^-i in micro-degrees.
  function automatic logic signed [ZW-1:0] atan_udeg(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 31'sd45000000;
      5'd1:    r = 31'sd26565051;
      5'd2:    r = 31'sd14036243;
      5'd3:    r = 31'sd7125016;
      5'd4:    r = 31'sd3576334;
      5'd5:    r = 31'sd1789911;
      5'd6:    r = 31'sd895174;
      5'd7:    r = 31'sd447614;
      5'd8:    r = 31'sd223811;
      5'd9:    r = 31'sd111906;
      5'd10:   r = 31'sd55953;
      5'd11:   r = 31'sd27976;
      5'd12:   r = 31'sd13988;
      5'd13:   r = 31'sd6994;
      5'd14:   r = 31'sd3497;
      5'd15:   r = 31'sd1749;
      5'd16:   r = 31'sd874;
      5'd17:   r = 31'sd437;
      5'd18:   r = 31'sd219;
      5'd19:   r = 31'sd109;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/joystick_polar_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Joystick polar converter
// Converts centered X/Y stick samples to angle, power and direction codes.
// ----------------------------------------------------------------------------
// The slave stream takes one sample per transaction: X, Y and the button bit.
// The first sample after reset becomes the stick center. The master stream
// returns one result per sample: angle in tenths of a degree, power percent,
// raw-threshold direction codes and the button bit.
// The magnitude is found by a two-bit-per-cycle square root, then divided by
// the radius one quotient bit per cycle, while a shared CORDIC stage resolves
// the angle and a bit-serial divider rounds it to tenths.
// s_tready is high only when no sample is in work. The result register holds
// one finished result; if the receiver stalls, the next result waits in the
// last step until the register frees up. Reset clears the center, the
// registers take their reset values and both streams go idle. Registers are
// written over the APB port.
// ----------------------------------------------------------------------------
module joystick_polar_converter_unit #(
  parameter int SAMPLE_BITS = jpc_pkg::SAMPLE_BITS_DEF,
  localparam int IW = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [IW-1:0] s_tdata,   // x_sample, y_sample, button_down, zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,   // angle_tenths, power_pct, horiz_dir, vert_dir,
                                   // button_out
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int DW  = SAMPLE_BITS + 1;
  localparam int XW  = SAMPLE_BITS + 12;
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int PW  = 2 * SAMPLE_BITS + 16;
  localparam int RW  = SAMPLE_BITS + 8;
  localparam int LA  = (RW > jpc_pkg::CORDIC_STEPS) ? RW : jpc_pkg::CORDIC_STEPS;
  localparam int CW  = $clog2(LA + 1);
  localparam int TW  = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [11:0] radius;
  logic [6:0]  deadzone;
  logic [11:0] right_th;
  logic [11:0] left_th;
  logic [11:0] up_th;
  logic [11:0] down_th;

  logic [2:0]  state;
  logic [CW-1:0] cnt;
  logic        centered;
  logic [SAMPLE_BITS-1:0] center_x;
  logic [SAMPLE_BITS-1:0] center_y;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic        button;
  logic [1:0]  hdir;
  logic [1:0]  vdir;
  logic        zero_vec;
  logic [SQW-1:0] sqx;
  logic [SQW-1:0] sqy;
  logic [PW-1:0] prod;
  logic [RW+1:0] rem;
  logic [RW-1:0] root;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  logic signed [jpc_pkg::ZW-1:0] cz;
  logic [11:0] drem;
  logic [RW-1:0] quo;
  logic [jpc_pkg::AW-1:0] arem;
  logic [jpc_pkg::ADW-1:0] adiv;
  logic [jpc_pkg::QA_BITS-1:0] aq;

  logic [SAMPLE_BITS-1:0] xs_in;
  logic [SAMPLE_BITS-1:0] ys_in;
  logic [SAMPLE_BITS-1:0] cx_eff;
  logic [SAMPLE_BITS-1:0] cy_eff;
  logic [TW-1:0] xs_ext;
  logic [TW-1:0] ys_ext;
  logic signed [2*DW-1:0] px;
  logic signed [2*DW-1:0] py;
  logic [PW-1:0] sum_ext;
  logic [PW-1:0] pm;
  logic [RW+1:0] rem_v;
  logic [RW+1:0] trial;
  logic signed [XW-1:0] xsh;
  logic signed [XW-1:0] ysh;
  logic signed [XW-1:0] dx_sc;
  logic signed [XW-1:0] dy_sc;
  logic signed [jpc_pkg::ZW-1:0] zw;
  logic [12:0] drem_v;
  logic [11:0] radius_eff;
  logic [6:0]  power;
  logic        keep;
  logic [11:0] angle;
  logic        in_acc;
  logic        out_free;
  logic        cfg_wr;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= jpc_pkg::RADIUS_RST;
      deadzone <= jpc_pkg::DEADZONE_RST;
      right_th <= jpc_pkg::RIGHT_RST;
      left_th  <= jpc_pkg::LEFT_RST;
      up_th    <= jpc_pkg::UP_RST;
      down_th  <= jpc_pkg::DOWN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        jpc_pkg::REG_RADIUS:   radius   <= pwdata[11:0];
        jpc_pkg::REG_DEADZONE: deadzone <= pwdata[6:0];
        jpc_pkg::REG_RIGHT:    right_th <= pwdata[11:0];
        jpc_pkg::REG_LEFT:     left_th  <= pwdata[11:0];
        jpc_pkg::REG_UP:       up_th    <= pwdata[11:0];
        jpc_pkg::REG_DOWN:     down_th  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      jpc_pkg::REG_RADIUS:   prdata = {20'd0, radius};
      jpc_pkg::REG_DEADZONE: prdata = {25'd0, deadzone};
      jpc_pkg::REG_RIGHT:    prdata = {20'd0, right_th};
      jpc_pkg::REG_LEFT:     prdata = {20'd0, left_th};
      jpc_pkg::REG_UP:       prdata = {20'd0, up_th};
      jpc_pkg::REG_DOWN:     prdata = {20'd0, down_th};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    xs_in  = s_tdata[SAMPLE_BITS-1:0];
    ys_in  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    cx_eff = centered ? center_x : xs_in;
    cy_eff = centered ? center_y : ys_in;
    xs_ext = TW'(xs_in);
    ys_ext = TW'(ys_in);
    px     = dx * dx;
    py     = dy * dy;
    sum_ext = PW'(sqx) + PW'(sqy);
    pm     = sum_ext * PW'(jpc_pkg::POWER_SCALE);
    rem_v  = {rem[RW-1:0], prod[PW-1:PW-2]};
    trial  = {root, 2'b01};
    xsh    = cx >>> cnt[4:0];
    ysh    = cy >>> cnt[4:0];
    dx_sc  = {{(XW-DW-8){dx[DW-1]}}, dx, 8'd0};
    dy_sc  = {{(XW-DW-8){dy[DW-1]}}, dy, 8'd0};
    if (cz < 0) begin
      zw = cz + jpc_pkg::DEG360;
    end else if (cz >= jpc_pkg::DEG360) begin
      zw = cz - jpc_pkg::DEG360;
    end else begin
      zw = cz;
    end
    radius_eff = (radius == 12'd0) ? 12'd1 : radius;
    drem_v = {drem, root[RW-1]};
    power  = (quo > RW'(jpc_pkg::POWER_MAX)) ? jpc_pkg::POWER_MAX : quo[6:0];
    keep   = (power >= deadzone);
    angle  = (!keep || zero_vec || aq == jpc_pkg::ANGLE_WRAP) ? 12'd0 : aq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      centered <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_PREP;
            centered <= 1'b1;
          end
        end
        ST_PREP: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ROOT;
          cnt   <= '0;
        end
        ST_ROOT: begin
          if (cnt == CW'(LA)) begin
            state <= ST_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == CW'(RW - 1)) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (!centered) begin
            center_x <= xs_in;
            center_y <= ys_in;
          end
          dx     <= $signed({1'b0, xs_in}) - $signed({1'b0, cx_eff});
          dy     <= $signed({1'b0, ys_in}) - $signed({1'b0, cy_eff});
          button <= s_tdata[2*SAMPLE_BITS];
          if (xs_ext > TW'(right_th)) begin
            hdir <= jpc_pkg::DIR_POS;
          end else if (xs_ext < TW'(left_th)) begin
            hdir <= jpc_pkg::DIR_NEG;
          end else begin
            hdir <= jpc_pkg::DIR_NONE;
          end
          if (ys_ext > TW'(up_th)) begin
            vdir <= jpc_pkg::DIR_POS;
          end else if (ys_ext < TW'(down_th)) begin
            vdir <= jpc_pkg::DIR_NEG;
          end else begin
            vdir <= jpc_pkg::DIR_NONE;
          end
        end
      end
      ST_PREP: begin
        sqx      <= px[SQW-1:0];
        sqy      <= py[SQW-1:0];
        zero_vec <= (dx == '0) && (dy == '0);
        if (dx < 0) begin
          cx <= -dx_sc;
          cy <= -dy_sc;
          cz <= jpc_pkg::DEG180;
        end else begin
          cx <= dx_sc;
          cy <= dy_sc;
          cz <= '0;
        end
      end
      ST_MUL: begin
        prod <= pm;
        rem  <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        if (cnt < CW'(RW)) begin
          prod <= {prod[PW-3:0], 2'b00};
          if (rem_v >= trial) begin
            rem  <= rem_v - trial;
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= rem_v;
            root <= {root[RW-2:0], 1'b0};
          end
        end
        if (cnt < CW'(jpc_pkg::CORDIC_STEPS)) begin
          if (!cy[XW-1]) begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + jpc_pkg::atan_udeg(cnt[4:0]);
          end else begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - jpc_pkg::atan_udeg(cnt[4:0]);
          end
        end
        if (cnt == CW'(LA)) begin
          drem <= '0;
          quo  <= '0;
          arem <= jpc_pkg::AW'(zw) + jpc_pkg::ROUND_HALF;
          adiv <= jpc_pkg::ANG_DIV_TOP;
          aq   <= '0;
        end
      end
      ST_DIV: begin
        root <= {root[RW-2:0], 1'b0};
        if (drem_v >= {1'b0, radius_eff}) begin
          drem <= 12'(drem_v - {1'b0, radius_eff});
          quo  <= {quo[RW-2:0], 1'b1};
        end else begin
          drem <= drem_v[11:0];
          quo  <= {quo[RW-2:0], 1'b0};
        end
        if (cnt >= CW'(RW - jpc_pkg::QA_BITS)) begin
          adiv <= adiv >> 1;
          if (arem >= jpc_pkg::AW'(adiv)) begin
            arem <= arem - jpc_pkg::AW'(adiv);
            aq   <= {aq[jpc_pkg::QA_BITS-2:0], 1'b1};
          end else begin
            aq   <= {aq[jpc_pkg::QA_BITS-2:0], 1'b0};
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {button, vdir, hdir, keep ? power : 7'd0, angle};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/jpc_checker.sv @@
// ----------------------------------------------------------------------------
// Joystick polar converter checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module jpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result transaction keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_power: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:12] <= jpc_pkg::POWER_MAX)
    else $error("power above full scale");

  a_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:0] < jpc_pkg::ANGLE_WRAP)
    else $error("angle not wrapped");

  a_dirs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:19] == jpc_pkg::DIR_NONE || m_tdata[20:19] == jpc_pkg::DIR_POS
                  || m_tdata[20:19] == jpc_pkg::DIR_NEG)
                 && (m_tdata[22:21] == jpc_pkg::DIR_NONE || m_tdata[22:21] == jpc_pkg::DIR_POS
                  || m_tdata[22:21] == jpc_pkg::DIR_NEG))
    else $error("invalid direction code");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind joystick_polar_converter_unit jpc_checker u_jpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
